@@ src/bile_pkg.sv @@
package bile_pkg;

  localparam logic [3:0] FUNC_PUSH       = 4'd0;
  localparam logic [3:0] FUNC_POP        = 4'd1;
  localparam logic [3:0] FUNC_INSERT     = 4'd2;
  localparam logic [3:0] FUNC_REMOVE_AT  = 4'd3;
  localparam logic [3:0] FUNC_ERASE      = 4'd4;
  localparam logic [3:0] FUNC_READ_AT    = 4'd5;
  localparam logic [3:0] FUNC_READ_FIRST = 4'd6;
  localparam logic [3:0] FUNC_READ_LAST  = 4'd7;
  localparam logic [3:0] FUNC_FILL       = 4'd8;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_NOOP   = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_FILL,
    CELL_ERASE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     keep;
  } cell_cmd_t;

endpackage

@@ src/bile_cell.sv @@
module bile_cell #(
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  bile_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]     pos,
  input  logic [CW-1:0]     cnt,
  input  logic [CW-1:0]     fill_n,
  input  logic [31:0]       val,
  input  logic [31:0]       head,
  input  logic [31:0]       left,
  input  logic [31:0]       right,
  output logic [31:0]       q
);
  import bile_pkg::*;

  logic [CW-1:0] idx;
  logic [CW:0]   idx_inc;
  logic [CW:0]   cnt_ext;
  logic [31:0]   q_next;

  assign idx     = CW'(INDEX);
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign cnt_ext = {1'b0, cnt};

  always_comb begin
    q_next = q;
    case (cmd.op)
      CELL_PUSH: begin
        if (idx == cnt) q_next = val;
      end
      CELL_INSERT: begin
        if (idx == pos) q_next = val;
        else if (idx > pos && idx <= cnt) q_next = left;
      end
      CELL_REMOVE: begin
        if (idx >= pos && idx_inc < cnt_ext) q_next = right;
      end
      CELL_FILL: begin
        if (idx < fill_n) q_next = val;
      end
      CELL_ERASE: begin
        if (idx_inc < cnt_ext) q_next = right;
        else if (idx_inc == cnt_ext && cmd.keep) q_next = head;
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ src/bounded_int_list_engine_unit.sv @@
// Every operation but erase_value returns its word in the cycle after acceptance.
// Erase_value shifts the list through the cell chain, one scan step per stored entry,
// so its word appears when the scan ends; an empty list skips the scan and answers like the others.
// Throughput: one word per cycle for all operations except erase_value, while out_stall is low.
// Reset clears the element count and the control state; entry contents are not cleared.
module bounded_int_list_engine_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         func,
  input  logic [5:0]         position,
  input  logic signed [31:0] value,
  input  logic [6:0]         fill_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [6:0]         list_size,
  output logic [1:0]         status,
  output logic [6:0]         erased_count
);
  import bile_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_left;
  logic [CW-1:0] erased;
  logic [31:0]   erase_val;

  logic [31:0]   cell_q [MAX_ENTRIES];
  cell_cmd_t     cmd;
  cell_cmd_t     cmd_dec;
  logic          fire;
  logic          full;
  logic          pos_bad;
  logic          keep;

  logic [CW-1:0] count_dec;
  logic [1:0]    res_status;
  logic          res_read;
  logic          erase_start;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] count_scan;
  logic [CW-1:0] erased_scan;

  assign fire    = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign full    = 32'(count) >= MAX_ENTRIES;
  assign pos_bad = 32'(position) >= 32'(count);
  assign keep    = cell_q[0] != erase_val;

  always_comb begin
    cmd_dec     = '{op: CELL_HOLD, keep: 1'b0};
    count_dec   = count;
    res_status  = ST_DONE;
    res_read    = 1'b0;
    erase_start = 1'b0;
    rd_idx      = '0;
    case (func)
      FUNC_PUSH: begin
        if (full) res_status = ST_REJECT;
        else begin
          cmd_dec.op = CELL_PUSH;
          count_dec  = CW'(count + 1'b1);
        end
      end
      FUNC_POP: begin
        if (count == '0) res_status = ST_NOOP;
        else count_dec = CW'(count - 1'b1);
      end
      FUNC_INSERT: begin
        if (pos_bad || full) res_status = ST_REJECT;
        else begin
          cmd_dec.op = CELL_INSERT;
          count_dec  = CW'(count + 1'b1);
        end
      end
      FUNC_REMOVE_AT: begin
        if (pos_bad) res_status = ST_NOOP;
        else begin
          cmd_dec.op = CELL_REMOVE;
          count_dec  = CW'(count - 1'b1);
        end
      end
      FUNC_ERASE: begin
        if (count != '0) erase_start = 1'b1;
      end
      FUNC_READ_AT: begin
        rd_idx = IW'(position);
        if (pos_bad) res_status = ST_REJECT;
        else res_read = 1'b1;
      end
      FUNC_READ_FIRST: begin
        if (count == '0) res_status = ST_REJECT;
        else res_read = 1'b1;
      end
      FUNC_READ_LAST: begin
        rd_idx = IW'(count - 1'b1);
        if (count == '0) res_status = ST_REJECT;
        else res_read = 1'b1;
      end
      FUNC_FILL: begin
        if (32'(fill_count) > MAX_ENTRIES) res_status = ST_REJECT;
        else begin
          cmd_dec.op = CELL_FILL;
          count_dec  = CW'(fill_count);
        end
      end
      default: begin
        res_status = ST_REJECT;
      end
    endcase
  end

  assign count_scan  = keep ? count : CW'(count - 1'b1);
  assign erased_scan = keep ? erased : CW'(erased + 1'b1);

  always_comb begin
    cmd = '{op: CELL_HOLD, keep: 1'b0};
    if (state == S_SCAN) cmd = '{op: CELL_ERASE, keep: keep};
    else if (fire) cmd = cmd_dec;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [31:0] left_q;
    logic [31:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid
      assign left_q = cell_q[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_body
      assign right_q = cell_q[i+1];
    end
    bile_cell #(
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .pos    (CW'(position)),
      .cnt    (count),
      .fill_n (CW'(fill_count)),
      .val    (value),
      .head   (cell_q[0]),
      .left   (left_q),
      .right  (right_q),
      .q      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && out_stall) ||
                   (state == S_IDLE && fire && !erase_start) ||
                   (state == S_SCAN && scan_left == CW'(1));
      case (state)
        S_IDLE: begin
          if (fire) begin
            if (erase_start) begin
              state <= S_SCAN;
            end else begin
              count <= count_dec;
            end
          end
        end
        S_SCAN: begin
          count <= count_scan;
          if (scan_left == CW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && fire) begin
      scan_left    <= count;
      erased       <= '0;
      erase_val    <= value;
      read_value   <= res_read ? cell_q[rd_idx] : '0;
      list_size    <= 7'(count_dec);
      status       <= res_status;
      erased_count <= '0;
    end else if (state == S_SCAN) begin
      scan_left <= CW'(scan_left - 1'b1);
      erased    <= erased_scan;
      if (scan_left == CW'(1)) begin
        read_value   <= '0;
        list_size    <= 7'(count_scan);
        status       <= ST_DONE;
        erased_count <= 7'(erased_scan);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ENTRIES)
    else $error("element count exceeds capacity");

  a_scan_output_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !out_valid)
    else $error("output word pending during erase scan");

  a_erase_enters_scan: assert property (@(posedge clk) disable iff (rst)
    (fire && func == FUNC_ERASE && count != '0) |=> (state == S_SCAN))
    else $error("erase on a nonempty list did not start a scan");

  a_scan_conserves: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_left != CW'(1)) |=>
      (32'(count) + 32'(erased) == $past(32'(count) + 32'(erased))))
    else $error("erase scan lost track of entries");

  a_scan_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_left != '0 && count != '0))
    else $error("erase scan running with nothing left");

endmodule
